FILE: src/rspe_pkg.sv
`default_nettype none
package rspe_pkg;

    localparam int MAX_PARITY = 30;
    localparam int PCNT_W     = 5;
    localparam int NUM_COUNTS = 1 << PCNT_W;

    localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(10);
    localparam logic [8:0]        GF_REDUCE  = 9'h11D;

    typedef logic [7:0] gf_byte_t;
    typedef gf_byte_t [MAX_PARITY-1:0] rem_t;
    typedef rem_t [NUM_COUNTS-1:0] gen_tab_t;

    // one finished block on its way to the output side
    typedef struct packed {
        rem_t              rem;
        logic [PCNT_W-1:0] len;
        logic              bad;
    } blk_t;

    function automatic gf_byte_t gf_mul(gf_byte_t a, gf_byte_t b);
        logic [8:0] x;
        gf_byte_t   acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc ^= x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x ^= GF_REDUCE;
        end
        return acc;
    endfunction

    function automatic logic count_ok(logic [PCNT_W-1:0] n);
        logic listed;
        listed = (n == PCNT_W'(7))  || (n == PCNT_W'(10)) || (n == PCNT_W'(13)) ||
                 (n == PCNT_W'(15)) || (n == PCNT_W'(16)) || (n == PCNT_W'(17)) ||
                 (n == PCNT_W'(18)) || (n == PCNT_W'(20)) || (n == PCNT_W'(22)) ||
                 (n == PCNT_W'(24)) || (n == PCNT_W'(26)) || (n == PCNT_W'(28)) ||
                 (n == PCNT_W'(30));
        return listed && (int'(n) <= MAX_PARITY);
    endfunction

    // entry [n][k] holds coefficient k+1 of g(x) = prod (x - a^i), i < n
    function automatic gen_tab_t build_gen_tab();
        gen_tab_t t;
        gf_byte_t g [0:MAX_PARITY];
        gf_byte_t r;
        t = '0;
        for (int n = 0; n < NUM_COUNTS; n++) begin
            if (count_ok(PCNT_W'(n))) begin
                for (int k = 0; k <= MAX_PARITY; k++) g[k] = '0;
                g[0] = 8'd1;
                r    = 8'd1;
                for (int d = 0; d < n; d++) begin
                    g[d+1] = gf_mul(r, g[d]);
                    for (int k = d; k >= 1; k--) g[k] ^= gf_mul(r, g[k-1]);
                    r = gf_mul(r, 8'd2);
                end
                for (int k = 0; k < MAX_PARITY; k++) t[n][k] = g[k+1];
            end
        end
        return t;
    endfunction

    localparam gen_tab_t GEN_TAB = build_gen_tab();

endpackage
`default_nettype wire

FILE: src/rspe_front.sv
`default_nettype none
module rspe_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [rspe_pkg::PCNT_W-1:0] cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_message_byte,
    input  wire logic                      s_block_end,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output rspe_pkg::blk_t                 q_data
);
    import rspe_pkg::*;

    logic [PCNT_W-1:0] parity_count_reg;
    rem_t              rem_reg;
    rem_t              rem_next;
    rem_t              coef;
    gf_byte_t          fb;
    logic              ok;
    logic              accept;

    assign ok      = count_ok(parity_count_reg);
    assign coef    = GEN_TAB[parity_count_reg];
    assign fb      = s_message_byte ^ rem_reg[0];
    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    // LFSR step: shift toward index 0, fold in fb * g
    always_comb begin
        for (int k = 0; k < MAX_PARITY; k++) begin
            if (k < int'(parity_count_reg)) begin
                rem_next[k] = gf_mul(fb, coef[k]);
                if (k + 1 < int'(parity_count_reg)) rem_next[k] ^= rem_reg[k+1];
            end else begin
                rem_next[k] = '0;
            end
        end
    end

    assign q_valid = s_valid && s_block_end;

    always_comb begin
        if (ok) begin
            q_data.rem = rem_next;
            q_data.len = parity_count_reg;
            q_data.bad = 1'b0;
        end else begin
            q_data.rem = '0;
            q_data.len = PCNT_W'(1);
            q_data.bad = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_count_reg <= PCNT_RESET;
            rem_reg          <= '0;
        end else if (cfg_we) begin
            parity_count_reg <= cfg_wdata;
            rem_reg          <= '0;
        end else if (accept) begin
            if (!ok || s_block_end) rem_reg <= '0;
            else                    rem_reg <= rem_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/rspe_queue.sv
`default_nettype none
module rspe_queue (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire rspe_pkg::blk_t push_data,
    output logic         pop_valid,
    input  wire logic    pop_ready,
    output rspe_pkg::blk_t pop_data
);
    import rspe_pkg::*;

    blk_t       mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)      count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

FILE: src/rspe_back.sv
`default_nettype none
module rspe_back (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    q_valid,
    output logic         q_ready,
    input  wire rspe_pkg::blk_t q_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output logic [7:0]   m_parity_byte,
    output logic         m_run_last,
    output logic         m_bad_count
);
    import rspe_pkg::*;

    rem_t              sh_reg;
    logic [PCNT_W-1:0] left_reg;
    logic              bad_reg;
    logic              active_reg;
    logic              m_valid_reg;
    gf_byte_t          m_parity_byte_reg;
    logic              m_run_last_reg;
    logic              m_bad_count_reg;
    logic              emit;
    logic              last_emit;
    logic              load;

    assign emit      = active_reg && (!m_valid_reg || m_ready);
    assign last_emit = emit && (left_reg == PCNT_W'(1));
    assign q_ready   = !active_reg || last_emit;
    assign load      = q_valid && q_ready;

    assign m_valid       = m_valid_reg;
    assign m_parity_byte = m_parity_byte_reg;
    assign m_run_last    = m_run_last_reg;
    assign m_bad_count   = m_bad_count_reg;

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_parity_byte_reg <= sh_reg[0];
            m_run_last_reg    <= (left_reg == PCNT_W'(1));
            m_bad_count_reg   <= bad_reg;
        end
        // a new block loads over the final shift of the previous one
        if (load) begin
            sh_reg   <= q_data.rem;
            left_reg <= q_data.len;
            bad_reg  <= q_data.bad;
        end else if (emit) begin
            sh_reg   <= sh_reg >> 8;
            left_reg <= left_reg - PCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit)         m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            if (load)           active_reg <= 1'b1;
            else if (last_emit) active_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

FILE: src/reed_solomon_parity_encoder_top.sv
// Reed-Solomon parity encoder, GF(256), poly 0x11D, generator roots a^0..a^(n-1).
// Input channel (s_): one message byte per transaction, s_block_end on the
// last byte of a block. Output channel (m_): the n parity bytes of the block,
// highest-order coefficient first, m_run_last on the final one. An unsupported
// parity count gives a single transaction with m_bad_count=1, byte 0.
// cfg_we/cfg_wdata set the parity count (reset 10) and drop any partial block;
// write it only while the block is idle.
// Throughput: one message byte per cycle while s_ready is high; the LFSR next
// state is combinational. A block's parity run leaves the output register in order.
// A finished block passes from the LFSR through a queue slot and the output shifter
// into the output register, then one byte per cycle while m_ready is high.
// A 2-entry queue of finished blocks sits between the LFSR and the output
// shifter, so input continues while parity drains; s_ready drops only while
// both queue slots are full. A stall on m_ready holds the current byte.
// Reset (aresetn low, synchronous) clears the LFSR, queue and output valid.
`default_nettype none
module reed_solomon_parity_encoder_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [rspe_pkg::PCNT_W-1:0] cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [7:0]                  s_message_byte,
    input  wire logic                        s_block_end,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_parity_byte,
    output logic                             m_run_last,
    output logic                             m_bad_count
);
    import rspe_pkg::*;

    logic fq_valid;
    logic fq_ready;
    blk_t fq_data;
    logic qb_valid;
    logic qb_ready;
    blk_t qb_data;

    rspe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_message_byte(s_message_byte),
        .s_block_end   (s_block_end),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    rspe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(fq_valid),
        .push_ready(fq_ready),
        .push_data (fq_data),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_data  (qb_data)
    );

    rspe_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_parity_byte(m_parity_byte),
        .m_run_last   (m_run_last),
        .m_bad_count  (m_bad_count)
    );

endmodule
`default_nettype wire

FILE: bench/rs_parity_checker.sv
`default_nettype none
// Watches both channels and the count register, keeps its own copy of the parity
// LFSR and compares every output transaction with the oldest predicted byte.
module rs_parity_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [rspe_pkg::PCNT_W-1:0] cfg_wdata,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire logic [7:0]                  s_message_byte,
    input  wire logic                        s_block_end,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire logic [7:0]                  m_parity_byte,
    input  wire logic                        m_run_last,
    input  wire logic                        m_bad_count,
    output int                               pending,
    output int                               fail_count
);
    localparam int NPAR = rspe_pkg::MAX_PARITY;

    typedef struct packed {
        logic [7:0] parity;
        logic       last;
        logic       bad;
    } parity_exp_t;

    parity_exp_t parity_q[$];
    parity_exp_t head;

    logic [7:0] gf_exp [0:254];
    logic [7:0] gf_log [0:255];

    logic [rspe_pkg::PCNT_W-1:0] cur_count;
    logic [7:0] remainder [0:NPAR-1];
    logic [7:0] gen_coef  [0:NPAR];   // [0] is the x^n coefficient

    initial begin
        logic [7:0] x;
        fail_count = 0;
        pending    = 0;
        x = 8'd1;
        for (int i = 0; i < 255; i++) begin
            gf_exp[i] = x;
            gf_log[x] = 8'(i);
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
        end
        gf_log[0] = 8'd0;
    end

    function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
        if (a == 8'd0 || b == 8'd0)
            return 8'd0;
        return gf_exp[(int'(gf_log[a]) + int'(gf_log[b])) % 255];
    endfunction

    function automatic logic count_supported(logic [rspe_pkg::PCNT_W-1:0] n);
        case (int'(n))
            7, 10, 13, 15, 16, 17, 18, 20, 22, 24, 26, 28, 30: return int'(n) <= NPAR;
            default: return 1'b0;
        endcase
    endfunction

    task automatic clear_remainder();
        for (int k = 0; k < NPAR; k++)
            remainder[k] = 8'd0;
    endtask

    // new count: drop the partial block and rebuild prod (x + a^i)
    task automatic load_count(logic [rspe_pkg::PCNT_W-1:0] n);
        logic [7:0] root;
        cur_count = n;
        clear_remainder();
        for (int k = 0; k <= NPAR; k++)
            gen_coef[k] = 8'd0;
        gen_coef[0] = 8'd1;
        if (count_supported(n)) begin
            for (int i = 0; i < int'(n); i++) begin
                root = gf_exp[i];
                for (int k = i + 1; k >= 1; k--)
                    gen_coef[k] = gen_coef[k] ^ gf_times(root, gen_coef[k-1]);
            end
        end
    endtask

    task automatic absorb_byte(logic [7:0] b, logic last);
        int          n;
        logic [7:0]  fb;
        parity_exp_t e;
        n = int'(cur_count);
        if (!count_supported(cur_count)) begin
            clear_remainder();
            if (last) begin
                e.parity = 8'd0;
                e.last   = 1'b1;
                e.bad    = 1'b1;
                parity_q.push_back(e);
            end
        end else begin
            fb = b ^ remainder[0];
            for (int k = 0; k < n - 1; k++)
                remainder[k] = remainder[k+1];
            remainder[n-1] = 8'd0;
            if (fb != 8'd0) begin
                for (int k = 0; k < n; k++)
                    remainder[k] = remainder[k] ^ gf_times(fb, gen_coef[k+1]);
            end
            if (last) begin
                for (int k = 0; k < n; k++) begin
                    e.parity = remainder[k];
                    e.last   = (k == n - 1);
                    e.bad    = 1'b0;
                    parity_q.push_back(e);
                end
                clear_remainder();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parity_q.delete();
            load_count(rspe_pkg::PCNT_RESET);
        end else begin
            // output side first: nothing leaves in the cycle its block ends
            if (m_valid && m_ready) begin
                if (parity_q.size() == 0) begin
                    $error("unexpected output transaction: parity_byte %0h", m_parity_byte);
                    fail_count++;
                end else begin
                    head = parity_q.pop_front();
                    if (m_parity_byte !== head.parity) begin
                        $error("parity_byte: expected %0h, got %0h", head.parity, m_parity_byte);
                        fail_count++;
                    end
                    if (m_run_last !== head.last) begin
                        $error("run_last: expected %0b, got %0b", head.last, m_run_last);
                        fail_count++;
                    end
                    if (m_bad_count !== head.bad) begin
                        $error("bad_count: expected %0b, got %0b", head.bad, m_bad_count);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                load_count(cfg_wdata);
            if (s_valid && s_ready)
                absorb_byte(s_message_byte, s_block_end);
        end
        pending <= parity_q.size();
    end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
    import rspe_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 130;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              cfg_we         = 1'b0;
    logic [PCNT_W-1:0] cfg_wdata      = '0;
    logic              s_valid        = 1'b0;
    logic [7:0]        s_message_byte = 8'd0;
    logic              s_block_end    = 1'b0;
    logic              m_ready        = 1'b0;
    logic              hold_go        = 1'b0;

    wire logic       s_ready;
    wire logic       m_valid;
    wire logic [7:0] m_parity_byte;
    wire logic       m_run_last;
    wire logic       m_bad_count;

    int pending;
    int fail_count;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int stall_cycles  = 0;

    always #1 aclk = ~aclk;

    reed_solomon_parity_encoder_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_byte (s_message_byte),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parity_byte  (m_parity_byte),
        .m_run_last     (m_run_last),
        .m_bad_count    (m_bad_count)
    );

    rs_parity_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_byte (s_message_byte),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_parity_byte  (m_parity_byte),
        .m_run_last     (m_run_last),
        .m_bad_count    (m_bad_count),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // receiver: random backpressure, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go <= 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic logic [PCNT_W-1:0] good_count(int idx);
        case (idx)
            0:       return PCNT_W'(7);
            1:       return PCNT_W'(10);
            2:       return PCNT_W'(13);
            3:       return PCNT_W'(15);
            4:       return PCNT_W'(16);
            5:       return PCNT_W'(17);
            6:       return PCNT_W'(18);
            7:       return PCNT_W'(20);
            8:       return PCNT_W'(22);
            9:       return PCNT_W'(24);
            10:      return PCNT_W'(26);
            11:      return PCNT_W'(28);
            default: return PCNT_W'(30);
        endcase
    endfunction

    // entered and left at a clock edge; returns at the edge of the transaction
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_message_byte <= b;
        s_block_end    <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_block(int len, logic terminated, logic zero_fill);
        for (int i = 0; i < len; i++)
            send_byte(zero_fill ? 8'd0 : 8'($urandom_range(255)),
                      terminated && (i == len - 1));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(logic [PCNT_W-1:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_segment(inout int sent);
        logic [PCNT_W-1:0] n;
        int                blocks;
        int                len;
        if ($urandom_range(99) < 15)
            n = PCNT_W'($urandom_range(31));
        else
            n = good_count($urandom_range(12));
        write_count(n);
        blocks = $urandom_range(6, 2);
        for (int k = 0; k < blocks; k++) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            send_block(len, 1'b1, $urandom_range(19) == 0);
            sent += len;
        end
        // unfinished block, abandoned by the next count write
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(5, 1);
            send_block(len, 1'b0, 1'b0);
            sent += len;
        end
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        src_idle_pct  = 16;
        sink_idle_pct = 74;

        // reset count 10: zero feedback only, then a mixed block
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        write_count(PCNT_W'(7));
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        write_count(PCNT_W'(30));
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b1);
        // unsupported counts give a single flagged transaction
        write_count(PCNT_W'(0));
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        write_count(PCNT_W'(31));
        send_byte(8'hFF, 1'b1);
        // partial block dropped by rewriting the count
        write_count(PCNT_W'(16));
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        write_count(PCNT_W'(16));
        send_byte(8'h7E, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 16;
                    sink_idle_pct = 74;
                end
                1: begin
                    src_idle_pct  = 74;
                    sink_idle_pct = 16;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            sent = 0;
            if (phase == 2) begin
                // long output stall while short blocks keep coming: fills the block queue
                write_count(PCNT_W'(30));
                hold_go <= 1'b1;
                for (int k = 0; k < 12; k++)
                    send_byte(8'($urandom_range(255)), 1'b1);
                sent += 12;
                drain();
            end
            while (sent < PHASE_ITEMS)
                run_segment(sent);
        end

        drain();
        repeat (12) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
src/rspe_pkg.sv
src/rspe_front.sv
src/rspe_queue.sv
src/rspe_back.sv
src/reed_solomon_parity_encoder_top.sv
bench/rs_parity_checker.sv
bench/testbench.sv
